FILE: rtl/evad_pkg.sv
// Shared types and constants of the energy voice activity detector.
`default_nettype none

package evad_pkg;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 31;   // largest square is 2**30
	localparam int ENERGY_W   = 41;
	localparam int HANG_W     = 16;
	localparam int THR_W      = 16;
	localparam int THR_SQ_W   = 2 * THR_W;
	localparam int HANG_MS_W  = 12;
	localparam int MS_SHIFT   = 4;    // 16 samples per millisecond
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HANG_MS   = CFG_IDX_W'(1);

	// Register reset values
	localparam logic [THR_W-1:0]     THRESHOLD_RESET = THR_W'(300);
	localparam logic [HANG_MS_W-1:0] HANG_MS_RESET   = HANG_MS_W'(150);
	localparam logic [THR_SQ_W-1:0]  THR_SQ_RESET    = THR_SQ_W'(300 * 300);

	localparam int DEFAULT_MAX_FRAME_SAMPLES = 1024;

	// Queue between front and back; depth is a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// One classified sample as it travels through the queue
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            last;
	} evad_item_t;

endpackage

`default_nettype wire

FILE: rtl/evad_front.sv
// Front end: takes samples in, squares them and hands them to the queue.
`default_nettype none

module evad_front import evad_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       frame_end,
	output logic                            push_valid,
	input  wire logic                       push_ready,
	output evad_item_t                      push_item
);

	logic signed [2*SAMPLE_W-1:0] sq_full;
	logic                         valid_s1;
	evad_item_t                   item_s1;

	// Square the incoming sample
	assign sq_full = sample * sample;

	// Take a new sample whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the squared sample and its frame mark
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.sq   <= sq_full[SQ_W-1:0];
			item_s1.last <= frame_end;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

FILE: rtl/evad_queue.sv
// Short first-in first-out queue between the front end and the back end.
`default_nettype none

module evad_queue import evad_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire evad_item_t push_item,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output evad_item_t      pop_item
);

	evad_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store the entry on a push transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QFILL_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (fill_q == $past(fill_q) + QFILL_W'(1)))
		else $error("queue fill count did not grow on push");

endmodule

`default_nettype wire

FILE: rtl/evad_back.sv
// Back end: accumulates frame energy, decides speech with hangover.
`default_nettype none

module evad_back import evad_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = DEFAULT_MAX_FRAME_SAMPLES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire evad_item_t           pop_item,
	input  wire logic [THR_W-1:0]     threshold_rms,
	input  wire logic [HANG_MS_W-1:0] hang_ms,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      speech,
	output logic                      by_energy
);

	localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int LIM_W = THR_SQ_W + CNT_W;
	localparam int CMP_W = (LIM_W > ENERGY_W) ? LIM_W : ENERGY_W;

	logic [THR_SQ_W-1:0] thr_prod;
	logic [THR_SQ_W-1:0] thr_sq_q;

	logic [ENERGY_W-1:0] energy_q;
	logic [CNT_W-1:0]    count_q;
	logic                counting;
	logic [ENERGY_W-1:0] energy_add;
	logic [CNT_W-1:0]    count_add;
	logic                take;

	logic                valid_s2;
	logic [ENERGY_W-1:0] energy_s2;
	logic [CNT_W-1:0]    count_s2;
	logic                s2_ready;
	logic                out_free;
	logic                fire;
	logic [LIM_W-1:0]    limit;
	logic                energetic;
	logic [HANG_W-1:0]   count_ext;
	logic [HANG_W-1:0]   hang_reload;
	logic [HANG_W-1:0]   hang_next;
	logic                speech_next;

	logic [HANG_W-1:0]   hang_q;
	logic                out_valid_q;
	logic                speech_q;
	logic                by_energy_q;

	// Keep threshold squared ready for the frame decision
	assign thr_prod = THR_SQ_W'(threshold_rms) * THR_SQ_W'(threshold_rms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= THR_SQ_RESET;
		end else begin
			thr_sq_q <= thr_prod;
		end
	end

	// Add the square while the frame is below its cap
	assign counting   = (count_q < CNT_W'(MAX_FRAME_SAMPLES));
	assign energy_add = energy_q + (counting ? ENERGY_W'(pop_item.sq) : '0);
	assign count_add  = count_q + (counting ? CNT_W'(1) : '0);

	assign out_free  = !out_valid_q || out_ready;
	assign s2_ready  = !valid_s2 || out_free;
	assign pop_ready = !pop_item.last || s2_ready;
	assign take      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			count_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				if (pop_item.last) begin
					energy_q <= '0;
					count_q  <= '0;
				end else begin
					energy_q <= energy_add;
					count_q  <= count_add;
				end
			end
			if (s2_ready) begin
				valid_s2 <= take && pop_item.last;
			end
		end
	end

	// Hand the finished frame totals to the decision stage
	always_ff @(posedge clk) begin
		if (take && pop_item.last) begin
			energy_s2 <= energy_add;
			count_s2  <= count_add;
		end
	end

	// Decide speech and update the hangover counter
	assign fire        = valid_s2 && out_free;
	assign limit       = LIM_W'(thr_sq_q) * LIM_W'(count_s2);
	assign energetic   = CMP_W'(energy_s2) > CMP_W'(limit);
	assign count_ext   = HANG_W'(count_s2);
	assign hang_reload = HANG_W'(hang_ms) << MS_SHIFT;

	always_comb begin
		hang_next   = hang_q;
		speech_next = 1'b0;
		priority if (energetic) begin
			hang_next   = hang_reload;
			speech_next = 1'b1;
		end else if (hang_q != '0) begin
			hang_next   = (hang_q > count_ext) ? hang_q - count_ext : '0;
			speech_next = 1'b1;
		end else begin
			hang_next   = hang_q;
			speech_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hang_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				hang_q      <= hang_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk) begin
		if (fire) begin
			speech_q    <= speech_next;
			by_energy_q <= energetic;
		end
	end

	assign out_valid = out_valid_q;
	assign speech    = speech_q;
	assign by_energy = by_energy_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_SAMPLES))
		else $error("sample count beyond frame cap");

	a_energy_is_speech: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && by_energy_q) |-> speech_q)
		else $error("energetic frame not flagged as speech");

	a_hang_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && energetic) |=> (hang_q == $past(hang_reload)))
		else $error("hangover not reloaded on energetic frame");

endmodule

`default_nettype wire

FILE: rtl/energy_voice_activity_detector_core.sv
// Top level of the energy voice activity detector: registers, front, queue, back.
// A frame's last sample gives its result on out_valid after its transfer passes the square stage,
// the queue, the frame-total register and the output register, and later while the queue holds items.
// Throughput: one sample per cycle while in_ready is high, set by the single squarer and accumulator adders.
// A result waiting in the output register does not block samples until the queue fills.
// Reset (arst_n low, asynchronous) clears the frame sums, hangover and queue and loads
// threshold_rms = 300 and hang_ms = 150; no clearing pass is needed.
`default_nettype none

module energy_voice_activity_detector_core import evad_pkg::*; #(
	parameter int MAX_FRAME_SAMPLES = DEFAULT_MAX_FRAME_SAMPLES
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	input  wire logic                        frame_end,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             speech,
	output logic                             by_energy,
	input  wire logic                        cfg_we,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]       cfg_wdata
);

	logic [THR_W-1:0]     threshold_q;
	logic [HANG_MS_W-1:0] hang_ms_q;

	logic       push_valid;
	logic       push_ready;
	evad_item_t push_item;
	logic       pop_valid;
	logic       pop_ready;
	evad_item_t pop_item;

	// Write configuration registers; other indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			hang_ms_q   <= HANG_MS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_wdata[THR_W-1:0];
				REG_HANG_MS:   hang_ms_q   <= cfg_wdata[HANG_MS_W-1:0];
				default: begin
					threshold_q <= threshold_q;
					hang_ms_q   <= hang_ms_q;
				end
			endcase
		end
	end

	evad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.frame_end  (frame_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	evad_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	evad_back #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.threshold_rms (threshold_q),
		.hang_ms       (hang_ms_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.speech        (speech),
		.by_energy     (by_energy)
	);

endmodule

`default_nettype wire
